/* src/cpr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_pkg
// shared types and constants for the clock page replacement block
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int unsigned PAGE_BITS = 20;
  localparam int unsigned SLOTS_DEF = 16;

  typedef enum logic [1:0] {
    CMD_ACCESS = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_VICTIM = 2'd2,
    CMD_NONE   = 2'd3
  } cpr_cmd_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_ABSENT = 2'd3
  } cpr_status_e;

  typedef struct packed {
    cpr_cmd_e             cmd;
    logic [PAGE_BITS-1:0] page_number;
    logic                 accessed_flag;
  } cpr_req_t;

  typedef struct packed {
    cpr_status_e          status;
    logic [PAGE_BITS-1:0] victim_page;
    logic                 victim_valid;
  } cpr_rsp_t;

endpackage

/* src/cpr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module cpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/clock_page_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_page_replacement
// second-chance page replacement over a ring of resident pages
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its answer appears on
// rsp_o for exactly one cycle, flagged by rsp_valid_o, and cannot be held off.
// Page numbers live in a ram with one write and one registered read port,
// walked one entry per cycle, marks in flops. An error answer or an unused
// command is answered straight from idle. Access scans the resident pages in
// order (sequential ram lookup). Insert moves pages up one ram move per cycle
// from the insert slot, then writes the page. Victim sweeps marks, reads the
// victim, moves pages above it down. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module clock_page_replacement #(
  parameter int unsigned SLOTS = cpr_pkg::SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cpr_pkg::cpr_req_t req_i,
  output logic              rsp_valid_o,
  output cpr_pkg::cpr_rsp_t rsp_o
);

  import cpr_pkg::*;

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  typedef enum logic [6:0] {
    S_IDLE       = 7'b0000001,
    S_ACC_SCAN   = 7'b0000010,
    S_INS_SHIFT  = 7'b0000100,
    S_INS_WRITE  = 7'b0001000,
    S_VIC_SEARCH = 7'b0010000,
    S_VIC_READ   = 7'b0100000,
    S_VIC_SHIFT  = 7'b1000000
  } cpr_state_e;

  cpr_state_e           state_q, state_d;
  cpr_req_t             req_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     hand_q, hand_d;
  logic [IDX_W-1:0]     ptr_q, ptr_d;
  logic [PAGE_BITS-1:0] vpage_q, vpage_d;
  logic [SLOTS-1:0]     marks_q, marks_d;
  logic                 rsp_valid_q, rsp_valid_d;
  cpr_rsp_t             rsp_q, rsp_d;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [PAGE_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [PAGE_BITS-1:0] ram_rdata;

  logic                 accept;
  logic [CNT_W-1:0]     count_dec;
  logic [CNT_W-1:0]     hand_dec;
  logic [IDX_W-1:0]     count_m1;
  logic [IDX_W-1:0]     at_w;
  logic [IDX_W-1:0]     ptr_p1;
  logic [IDX_W-1:0]     ptr_m1;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign count_dec   = count_q - 1'b1;
  assign hand_dec    = hand_q - 1'b1;
  assign count_m1    = count_dec[IDX_W-1:0];
  assign at_w        = (hand_q == '0) ? count_q[IDX_W-1:0] : hand_dec[IDX_W-1:0];
  assign ptr_p1      = ptr_q + 1'b1;
  assign ptr_m1      = ptr_q - 1'b1;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  cpr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (SLOTS),
    .ADDR_W(IDX_W)
  ) u_page_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    hand_d      = hand_q;
    ptr_d       = ptr_q;
    vpage_d     = vpage_q;
    marks_d     = marks_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q;
    ram_wdata   = ram_rdata;
    ram_raddr   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rsp_d.victim_page  = '0;
          rsp_d.victim_valid = 1'b0;
          rsp_d.status       = STAT_OK;
          unique case (req_i.cmd)
            CMD_ACCESS: begin
              if (count_q == '0) begin
                rsp_d.status = STAT_ABSENT;
                rsp_valid_d  = 1'b1;
              end else begin
                ptr_d   = '0;
                state_d = S_ACC_SCAN;
              end
            end
            CMD_INSERT: begin
              if (count_q == CNT_W'(SLOTS)) begin
                rsp_d.status = STAT_FULL;
                rsp_valid_d  = 1'b1;
              end else if (count_q > CNT_W'(at_w)) begin
                ptr_d     = count_q[IDX_W-1:0];
                ram_raddr = count_m1;
                state_d   = S_INS_SHIFT;
              end else begin
                ptr_d   = at_w;
                state_d = S_INS_WRITE;
              end
            end
            CMD_VICTIM: begin
              if (count_q == '0) begin
                rsp_d.status = STAT_EMPTY;
                rsp_valid_d  = 1'b1;
              end else begin
                ptr_d   = (hand_q == '0) ? '0 : hand_dec[IDX_W-1:0];
                state_d = S_VIC_SEARCH;
              end
            end
            default: begin
              rsp_valid_d = 1'b1;
            end
          endcase
        end
      end

      S_ACC_SCAN: begin
        if (ram_rdata == req_q.page_number) begin
          marks_d[ptr_q] = 1'b1;
          rsp_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end else if (ptr_q == count_m1) begin
          rsp_d.status = STAT_ABSENT;
          rsp_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else begin
          ptr_d     = ptr_p1;
          ram_raddr = ptr_p1;
        end
      end

      S_INS_SHIFT: begin
        ram_we         = 1'b1;
        marks_d[ptr_q] = marks_q[ptr_m1];
        ptr_d          = ptr_m1;
        if (ptr_m1 == at_w) begin
          state_d = S_INS_WRITE;
        end else begin
          ram_raddr = ptr_m1 - 1'b1;
        end
      end

      S_INS_WRITE: begin
        ram_we         = 1'b1;
        ram_wdata      = req_q.page_number;
        marks_d[ptr_q] = req_q.accessed_flag;
        count_d        = count_q + 1'b1;
        if (hand_q != '0) begin
          hand_d = hand_q + 1'b1;
        end
        rsp_valid_d = 1'b1;
        state_d     = S_IDLE;
      end

      S_VIC_SEARCH: begin
        if (marks_q[ptr_q]) begin
          marks_d[ptr_q] = 1'b0;
          ptr_d          = (ptr_q == count_m1) ? '0 : ptr_p1;
        end else begin
          ram_raddr = ptr_q;
          state_d   = S_VIC_READ;
        end
      end

      S_VIC_READ: begin
        vpage_d = ram_rdata;
        hand_d  = (ptr_q == count_m1) ? '0 : CNT_W'(ptr_q) + 1'b1;
        if (ptr_q == count_m1) begin
          count_d            = count_dec;
          rsp_d.victim_page  = ram_rdata;
          rsp_d.victim_valid = 1'b1;
          rsp_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end else begin
          ram_raddr = ptr_p1;
          state_d   = S_VIC_SHIFT;
        end
      end

      S_VIC_SHIFT: begin
        ram_we         = 1'b1;
        marks_d[ptr_q] = marks_q[ptr_p1];
        if (ptr_p1 == count_m1) begin
          marks_d[ptr_p1]    = 1'b0;
          count_d            = count_dec;
          rsp_d.victim_page  = vpage_q;
          rsp_d.victim_valid = 1'b1;
          rsp_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end else begin
          ptr_d     = ptr_p1;
          ram_raddr = ptr_p1 + 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      hand_q      <= '0;
      ptr_q       <= '0;
      marks_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      hand_q      <= hand_d;
      ptr_q       <= ptr_d;
      marks_q     <= marks_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    vpage_q <= vpage_d;
    rsp_q   <= rsp_d;
  end

  // checks

  assert property (@(posedge clk_i) disable iff (!rst_ni) rsp_valid_o |-> !busy)
    else $error("answer shown while a word is still in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (count_q <= CNT_W'(SLOTS)) && (hand_q <= count_q))
    else $error("resident count or hand out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   rsp_valid_o && rsp_o.victim_valid |-> rsp_o.status == STAT_OK)
    else $error("victim returned with an error status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   accept && req_i.cmd == CMD_INSERT && count_q != CNT_W'(SLOTS)
                   |-> ##1 busy)
    else $error("insert of a page did not start the sequencer");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the clock page replacement block
// ----------------------------------------------------------------------------
// A queue of command words, filled at time zero, feeds a clocked driver that
// waits a random number of cycles before each word and sometimes holds off
// until every answer is back. A clocked monitor runs its own second-chance
// ring model on each word taken and checks every answer field by field
// against the oldest prediction. The stimulus starts with a short directed
// run covering the empty, absent, full and duplicate cases and inserts
// before the hand. Random blocks follow that alternate between filling and
// draining the ring, drawing most page numbers from a small pool so that
// accesses hit and duplicates occur.
// ----------------------------------------------------------------------------
module tb_top;
  import cpr_pkg::*;

  localparam int unsigned CLK_PERIOD = 20;
  localparam int unsigned SLOTS      = SLOTS_DEF;
  localparam int unsigned POOL_SIZE  = 12;

  typedef struct {
    cpr_req_t    word;
    int unsigned gap;
    bit          drain;
  } pending_word_t;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  cpr_req_t req_d  = '0;
  logic     rsp_valid_o;
  cpr_rsp_t rsp_o;

  pending_word_t        word_q[$];
  cpr_rsp_t             due_rsp_q[$];
  int unsigned          outstanding = 0;
  int unsigned          err_cnt     = 0;

  // ring model
  logic [PAGE_BITS-1:0] ring_page [SLOTS];
  bit                   ring_mark [SLOTS];
  int unsigned          ring_cnt  = 0;
  int unsigned          ring_hand = 0;

  logic [PAGE_BITS-1:0] page_pool [POOL_SIZE];

  int unsigned          gap_left  = 0;
  bit                   gap_armed = 1'b0;
  pending_word_t        next_word;
  cpr_rsp_t             want;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  clock_page_replacement DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_d),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  function automatic cpr_rsp_t clock_step(input cpr_req_t w);
    cpr_rsp_t    r;
    int unsigned i;
    int unsigned at;
    int unsigned h;
    int unsigned idx;
    bit          found;
    bit          done;
    r.status       = STAT_OK;
    r.victim_page  = '0;
    r.victim_valid = 1'b0;
    case (w.cmd)
      CMD_ACCESS: begin
        found = 1'b0;
        for (i = 0; i < ring_cnt; i++) begin
          if (!found && ring_page[i] == w.page_number) begin
            ring_mark[i] = 1'b1;
            found        = 1'b1;
          end
        end
        if (!found) r.status = STAT_ABSENT;
      end
      CMD_INSERT: begin
        if (ring_cnt >= SLOTS) begin
          r.status = STAT_FULL;
        end else begin
          at = (ring_hand == 0) ? ring_cnt : ring_hand - 1;
          for (i = ring_cnt; i > at; i--) begin
            ring_page[i] = ring_page[i-1];
            ring_mark[i] = ring_mark[i-1];
          end
          ring_page[at] = w.page_number;
          ring_mark[at] = w.accessed_flag;
          ring_cnt++;
          if (ring_hand != 0) ring_hand++;
        end
      end
      CMD_VICTIM: begin
        if (ring_cnt == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          h    = (ring_hand > ring_cnt) ? 0 : ring_hand;
          idx  = 0;
          done = 1'b0;
          while (!done) begin
            if (h == 0) h = 1;
            idx = h - 1;
            if (ring_mark[idx]) begin
              ring_mark[idx] = 1'b0;
              h = (h >= ring_cnt) ? 0 : h + 1;
            end else begin
              done = 1'b1;
            end
          end
          r.victim_page  = ring_page[idx];
          r.victim_valid = 1'b1;
          for (i = idx; i + 1 < ring_cnt; i++) begin
            ring_page[i] = ring_page[i+1];
            ring_mark[i] = ring_mark[i+1];
          end
          ring_mark[ring_cnt-1] = 1'b0;
          ring_cnt--;
          ring_hand = (h > ring_cnt) ? 0 : h;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic queue_word(input cpr_cmd_e cmd, input logic [PAGE_BITS-1:0] page,
                            input logic flag, input int unsigned gap, input bit drain);
    pending_word_t p;
    p.word.cmd           = cmd;
    p.word.page_number   = page;
    p.word.accessed_flag = flag;
    p.gap                = gap;
    p.drain              = drain;
    word_q.push_back(p);
  endtask

  function automatic logic [PAGE_BITS-1:0] pick_page(input int unsigned pool_pct);
    if ($urandom_range(0, 99) < pool_pct)
      return page_pool[$urandom_range(0, POOL_SIZE-1)];
    return PAGE_BITS'($urandom);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      req_d     <= '0;
      gap_left   = 0;
      gap_armed  = 1'b0;
    end else if (!(start && busy)) begin
      if (word_q.size() == 0) begin
        start <= 1'b0;
      end else begin
        if (!gap_armed) begin
          gap_left  = word_q[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (word_q[0].drain && (outstanding != 0 || start)) begin
          start <= 1'b0;
        end else begin
          next_word  = word_q.pop_front();
          req_d     <= next_word.word;
          start     <= 1'b1;
          gap_armed  = 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding <= 0;
    end else begin
      if (start && !busy) due_rsp_q.push_back(clock_step(req_d));
      if (rsp_valid_o) begin
        if (due_rsp_q.size() == 0) begin
          $error("answer word with no command outstanding");
          err_cnt++;
        end else begin
          want = due_rsp_q.pop_front();
          if (rsp_o.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, rsp_o.status);
            err_cnt++;
          end
          if (rsp_o.victim_page !== want.victim_page) begin
            $error("victim_page expected %05h got %05h", want.victim_page,
                   rsp_o.victim_page);
            err_cnt++;
          end
          if (rsp_o.victim_valid !== want.victim_valid) begin
            $error("victim_valid expected %0b got %0b", want.victim_valid,
                   rsp_o.victim_valid);
            err_cnt++;
          end
        end
      end
      outstanding <= due_rsp_q.size();
    end
  end

  initial begin
    int unsigned blk;
    int unsigned n;
    int unsigned roll;
    int unsigned ins_pct;
    int unsigned vic_pct;
    bit          no_idle;
    int unsigned gap;
    cpr_cmd_e    cmd;

    for (n = 0; n < SLOTS; n++) begin
      ring_page[n] = '0;
      ring_mark[n] = 1'b0;
    end
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (n = 2; n < POOL_SIZE; n++) page_pool[n] = PAGE_BITS'($urandom);

    // directed: empty, absent, unused command, duplicates
    queue_word(CMD_VICTIM, PAGE_BITS'($urandom), 1'($urandom), 0, 1'b0);
    queue_word(CMD_ACCESS, '0, 1'b0, 0, 1'b0);
    queue_word(CMD_NONE, '1, 1'b1, 1, 1'b0);
    queue_word(CMD_INSERT, '0, 1'b0, 0, 1'b0);
    queue_word(CMD_INSERT, '1, 1'b1, 0, 1'b0);
    queue_word(CMD_INSERT, '1, 1'b0, 2, 1'b0);
    queue_word(CMD_ACCESS, '1, 1'b0, 0, 1'b0);
    queue_word(CMD_ACCESS, 20'h12345, 1'b1, 0, 1'b0);
    queue_word(CMD_INSERT, 20'haaaaa, 1'b1, 0, 1'b0);
    // fill to the brim, then one more
    for (n = 0; n < SLOTS - 4; n++)
      queue_word(CMD_INSERT, page_pool[n], n[0], 0, 1'b0);
    queue_word(CMD_INSERT, 20'h55555, 1'b1, 0, 1'b1);
    // sweep clears marks, then insert before the hand
    queue_word(CMD_VICTIM, '0, 1'b0, 0, 1'b0);
    queue_word(CMD_INSERT, 20'h55555, 1'b0, 0, 1'b0);
    queue_word(CMD_VICTIM, '1, 1'b1, 3, 1'b0);

    // random blocks alternating between filling and draining the ring
    for (blk = 0; blk < 19; blk++) begin
      ins_pct = blk[0] ? 20 : 60;
      vic_pct = blk[0] ? 55 : 20;
      no_idle = ($urandom_range(0, 3) == 0);
      for (n = 0; n < 50; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_pct)                cmd = CMD_INSERT;
        else if (roll < ins_pct + vic_pct) cmd = CMD_VICTIM;
        else if (roll < 98)                cmd = CMD_ACCESS;
        else                               cmd = CMD_NONE;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        queue_word(cmd, pick_page(cmd == CMD_ACCESS ? 80 : 85), 1'($urandom), gap,
                   (n == 0) && (blk == 0 || $urandom_range(0, 3) == 0));
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (word_q.size() != 0 || start || outstanding != 0);
    repeat (100) @(negedge clk_i);

    if (due_rsp_q.size() != 0) begin
      $error("%0d answer words never arrived", due_rsp_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #15_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
